[hw/rtl/mscld_pkg.sv]
// shared types and constants of the multi-servo current-limited drive
package mscld_pkg;

    localparam int unsigned NUM_SERVOS_DEF      = 5;
    localparam int unsigned SPEED_DIV_DEF       = 8;
    localparam logic [7:0]  DEFAULT_CURRENT_DEF = 8'd200;

    localparam logic [11:0] RST_PWM_FLOOR = 12'd1000;

    localparam logic [7:0]  ANGLE_MIN      = 8'd1;
    localparam logic [7:0]  ANGLE_MAX      = 8'd180;
    localparam logic [7:0]  CUR_FOLLOW_MAX = 8'd5;
    localparam logic [7:0]  CUR_SPEED_MIN  = 8'd10;
    localparam logic [3:0]  HOLD_BACKOFF   = 4'd10;
    localparam logic [4:0]  DEG_SCALE      = 5'd25;
    localparam logic [3:0]  ANGLE_GAIN     = 4'd9;
    localparam logic [12:0] CMP_MAX        = 13'd8191;
    localparam logic [7:0]  ANGLE_SAT      = 8'd255;

    // divide by nine: ceil(2^16 / 9), exact for dividends below 6376
    localparam logic [12:0] DIV9_RECIP = 13'd7282;
    localparam int unsigned DIV9_SH    = 16;
    // divide by one hundred: ceil(2^27 / 100), exact for 20-bit dividends
    localparam logic [20:0] DIV100_RECIP = 21'd1342178;
    localparam int unsigned DIV100_SH    = 27;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET_MODE  = 3'd1,
        OP_SET_ANGLE = 3'd2,
        OP_SET_LIMIT = 3'd3,
        OP_SET_SPEED = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_ANGLE  = 2'd1,
        MODE_HOLD   = 2'd2
    } t_mode;

    localparam logic [7:0] MODE_VALUE_MAX = 8'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] servo_index;
        logic [7:0] set_value;
        logic [7:0] measured_angle;
        logic [7:0] measured_current;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  servo_echo;
        logic [12:0] drive_compare;
        logic [7:0]  reported_angle;
        logic [7:0]  reported_speed;
    } t_out_beat;

endpackage

[hw/rtl/mscld_ram.sv]
// generic single-port-write ram with registered read
module mscld_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/multi_servo_current_limited_drive.sv]
// top level of the multi-servo current-limited drive regulator
// each accepted beat steps through states read, mul1, level, calc, mul2, ang and done
// one item in flight at a time, held by the per-item sequencer that
//   reads the servo state ram, runs the multiply stages and writes back
// the next beat is taken while a finished result still waits at the output
// reset: synchronous active low; ram entries read as reset values until first written
module multi_servo_current_limited_drive #(
    parameter int unsigned NUM_SERVOS      = mscld_pkg::NUM_SERVOS_DEF,
    parameter int unsigned SPEED_DIV       = mscld_pkg::SPEED_DIV_DEF,
    parameter logic [7:0]  DEFAULT_CURRENT = mscld_pkg::DEFAULT_CURRENT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mscld_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mscld_pkg::t_out_beat o_out_beat,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [11:0]          i_cfg_data
);

    localparam int unsigned ADDR_W    = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int unsigned DIV_SH    = 19;
    localparam logic [19:0] DIV_RECIP = 20'((2**DIV_SH + SPEED_DIV - 1) / SPEED_DIV);
    localparam logic [15:0] RST_LEVEL =
        16'(32'(mscld_pkg::RST_PWM_FLOOR) * SPEED_DIV);

    typedef struct packed {
        logic [15:0] level;
        logic [7:0]  target;
        logic [7:0]  limit;
        logic [7:0]  speed;
        logic        last_zero;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);
    localparam t_entry RST_ENTRY = '{
        level:     RST_LEVEL,
        target:    8'd0,
        limit:     DEFAULT_CURRENT,
        speed:     8'd1,
        last_zero: 1'b1
    };

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_MUL1  = 8'b0000_0100,
        ST_LEVEL = 8'b0000_1000,
        ST_CALC  = 8'b0001_0000,
        ST_MUL2  = 8'b0010_0000,
        ST_ANG   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    mscld_pkg::t_in_beat  r_in;
    logic                 r_ok;
    t_entry               r_ent, n_ent;
    mscld_pkg::t_mode     r_mode;
    logic [9:0]           r_q;
    logic [15:0]          r_old_c;
    logic [15:0]          r_tgt;
    logic [15:0]          r_minl;
    logic [15:0]          r_lvl;
    logic                 r_save;
    logic [15:0]          r_cmp;
    logic [15:0]          r_c_saved;
    logic [7:0]           r_angle;
    logic [11:0]          r_pwm_floor;
    mscld_pkg::t_mode     r_servo_mode [NUM_SERVOS];
    mscld_pkg::t_mode     r_latched;
    logic [NUM_SERVOS-1:0] r_valid;
    logic                 r_out_valid;
    mscld_pkg::t_out_beat r_out;

    logic                 in_acc;
    logic                 out_free;
    logic                 in_ok;
    logic [ADDR_W+2:0]    in_idx_w, r_idx_w;
    logic [ADDR_W-1:0]    in_addr, r_addr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 ram_we;
    t_entry               rd_ent;

    logic [7:0]           deg;
    logic [12:0]          x25;
    logic [25:0]          prod9;
    logic [35:0]          prod_old, prod_new;
    logic [15:0]          c_new;
    logic [12:0]          tgt_sum;
    logic                 over;
    logic signed [17:0]   s_lvl, s_tgt, s_min, s_spd, s_up, s_dn, s_res;
    logic [15:0]          n_lvl;
    logic                 n_save;
    logic [7:0]           ang_clamp;
    logic [15:0]          ang_diff;
    logic [19:0]          ang_x9;
    logic [40:0]          ang_prod;
    logic [13:0]          ang_q;

    // handshakes
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_cfg_ready = 1'b1;

    // servo addressing
    assign in_ok    = {2'b00, i_in_beat.servo_index} < 5'(NUM_SERVOS);
    assign in_idx_w = {ADDR_W'(0), i_in_beat.servo_index};
    assign in_addr  = in_idx_w[ADDR_W-1:0];
    assign r_idx_w  = {ADDR_W'(0), r_in.servo_index};
    assign r_addr   = r_idx_w[ADDR_W-1:0];

    assign ram_we = (r_state == ST_CALC) && r_ok;

    mscld_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SERVOS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (n_ent),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = r_valid[r_addr] ? t_entry'(ram_rdata) : RST_ENTRY;

    // level of angle, first half
    assign deg   = ((r_mode == mscld_pkg::MODE_ANGLE) || (r_mode == mscld_pkg::MODE_HOLD))
                   ? r_ent.target : r_in.measured_angle;
    assign x25   = 13'(deg) * 13'(mscld_pkg::DEG_SCALE);
    assign prod9 = 26'(x25) * 26'(mscld_pkg::DIV9_RECIP);

    assign prod_old = 36'(r_ent.level) * 36'(DIV_RECIP);
    assign prod_new = 36'(r_lvl) * 36'(DIV_RECIP);
    assign c_new    = prod_new[DIV_SH +: 16];

    assign tgt_sum = 13'(r_pwm_floor) + {1'b0, r_q, 2'b00};

    // ramp
    assign over  = r_in.measured_current >= r_ent.limit;
    assign s_lvl = $signed({2'b00, r_ent.level});
    assign s_tgt = $signed({2'b00, r_tgt});
    assign s_min = $signed({2'b00, r_minl});
    assign s_spd = $signed({10'd0, r_ent.speed});

    always_comb begin
        s_up  = s_lvl + s_spd;
        s_dn  = s_lvl - s_spd;
        s_res = s_lvl;
        case (r_mode)
            mscld_pkg::MODE_ANGLE: begin
                if (over) begin
                    s_res = '0;
                end else if (s_lvl < s_tgt) begin
                    s_res = (s_up > s_tgt) ? s_tgt : s_up;
                end else if (s_lvl > s_tgt) begin
                    s_res = (s_dn < s_tgt) ? s_tgt : s_dn;
                end
            end
            mscld_pkg::MODE_HOLD: begin
                if (!over) begin
                    s_up  = s_lvl + 18'sd1;
                    s_res = (s_up > s_tgt) ? s_tgt : s_up;
                end else begin
                    s_dn  = s_lvl - $signed({14'd0, mscld_pkg::HOLD_BACKOFF});
                    s_res = (s_dn < s_min) ? s_min : s_dn;
                end
            end
            default: begin
                if (r_ent.last_zero && (r_in.measured_current < mscld_pkg::CUR_FOLLOW_MAX)) begin
                    s_res = s_tgt;
                end else begin
                    s_res = '0;
                end
            end
        endcase
    end

    assign n_lvl  = s_res[15:0];
    assign n_save = n_lvl >= r_minl;

    assign ang_clamp = (r_in.set_value < mscld_pkg::ANGLE_MIN) ? mscld_pkg::ANGLE_MIN :
                       (r_in.set_value > mscld_pkg::ANGLE_MAX) ? mscld_pkg::ANGLE_MAX :
                       r_in.set_value;

    always_comb begin
        n_ent = r_ent;
        case (r_in.opcode)
            mscld_pkg::OP_TICK: begin
                n_ent.last_zero = (n_lvl == 16'd0);
                if (n_save) begin
                    n_ent.level = n_lvl;
                end
            end
            mscld_pkg::OP_SET_ANGLE: n_ent.target = ang_clamp;
            mscld_pkg::OP_SET_LIMIT: n_ent.limit  = r_in.set_value;
            mscld_pkg::OP_SET_SPEED: n_ent.speed  = r_in.set_value;
            default: n_ent = r_ent;
        endcase
    end

    // angle of saved level
    assign ang_diff = r_c_saved - 16'(r_pwm_floor);
    assign ang_x9   = 20'(ang_diff) * 20'(mscld_pkg::ANGLE_GAIN);
    assign ang_prod = 41'(ang_x9) * 41'(mscld_pkg::DIV100_RECIP);
    assign ang_q    = ang_prod[mscld_pkg::DIV100_SH +: 14];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) begin
                n_state = ST_READ;
            end
            ST_READ:  n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_CALC;
            ST_CALC:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_ANG;
            ST_ANG:   n_state = ST_DONE;
            ST_DONE:  if (out_free) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_latched   <= mscld_pkg::MODE_FOLLOW;
            r_pwm_floor <= mscld_pkg::RST_PWM_FLOOR;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SERVOS; i++) begin
                r_servo_mode[i] <= mscld_pkg::MODE_FOLLOW;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_pwm_floor <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == ST_CALC) begin
                if ((r_in.opcode == mscld_pkg::OP_SET_MODE)
                        && (r_in.set_value <= mscld_pkg::MODE_VALUE_MAX)) begin
                    if (r_latched != mscld_pkg::MODE_FOLLOW) begin
                        for (int i = 0; i < NUM_SERVOS; i++) begin
                            r_servo_mode[i] <= mscld_pkg::t_mode'(r_in.set_value[1:0]);
                        end
                    end
                    r_latched <= mscld_pkg::t_mode'(r_in.set_value[1:0]);
                end else if (r_ok && ((r_in.opcode == mscld_pkg::OP_SET_ANGLE)
                        || (r_in.opcode == mscld_pkg::OP_SET_LIMIT)
                        || (r_in.opcode == mscld_pkg::OP_SET_SPEED))) begin
                    r_servo_mode[r_addr] <= r_latched;
                end
            end
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_beat;
            r_ok <= in_ok;
        end
        if (r_state == ST_READ) begin
            r_ent  <= rd_ent;
            r_mode <= r_servo_mode[r_addr];
        end
        if (r_state == ST_MUL1) begin
            r_q     <= prod9[mscld_pkg::DIV9_SH +: 10];
            r_old_c <= prod_old[DIV_SH +: 16];
        end
        if (r_state == ST_LEVEL) begin
            r_tgt  <= 16'(17'(tgt_sum) * 17'(SPEED_DIV));
            r_minl <= 16'(16'(r_pwm_floor) * 16'(SPEED_DIV));
        end
        if (r_state == ST_CALC) begin
            r_ent  <= n_ent;
            r_lvl  <= n_lvl;
            r_save <= n_save;
        end
        if (r_state == ST_MUL2) begin
            if (r_in.opcode == mscld_pkg::OP_TICK) begin
                r_cmp     <= c_new;
                r_c_saved <= r_save ? c_new : r_old_c;
            end else begin
                r_cmp     <= r_old_c;
                r_c_saved <= r_old_c;
            end
        end
        if (r_state == ST_ANG) begin
            if (r_c_saved < 16'(r_pwm_floor)) begin
                r_angle <= 8'd0;
            end else if (ang_q > 14'(mscld_pkg::ANGLE_SAT)) begin
                r_angle <= mscld_pkg::ANGLE_SAT;
            end else begin
                r_angle <= ang_q[7:0];
            end
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out.servo_echo <= r_in.servo_index;
            if (r_ok) begin
                r_out.drive_compare  <= (r_cmp > 16'(mscld_pkg::CMP_MAX))
                                        ? mscld_pkg::CMP_MAX : r_cmp[12:0];
                r_out.reported_angle <= r_angle;
                r_out.reported_speed <=
                    ((r_in.measured_current > mscld_pkg::CUR_SPEED_MIN)
                     && (r_in.measured_current < r_ent.limit)) ? r_ent.speed : 8'd0;
            end else begin
                r_out.drive_compare  <= '0;
                r_out.reported_angle <= '0;
                r_out.reported_speed <= '0;
            end
        end
    end

endmodule

[hw/rtl/mscld_checker.sv]
// port-level checks of the multi-servo drive, bound to the top level
module mscld_checker #(
    parameter int unsigned NUM_SERVOS = mscld_pkg::NUM_SERVOS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input mscld_pkg::t_out_beat o_out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // a fresh result frees the input side
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled when result appeared");

    // unknown servo gives an empty result
    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({2'b00, o_out_beat.servo_echo} >= 5'(NUM_SERVOS))
        |-> (o_out_beat.drive_compare == 13'd0) && (o_out_beat.reported_angle == 8'd0)
            && (o_out_beat.reported_speed == 8'd0))
        else $error("result for unknown servo not zero");

endmodule

bind multi_servo_current_limited_drive mscld_checker #(
    .NUM_SERVOS (NUM_SERVOS)
) u_mscld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

[tb/sv/servo_drive_check.sv]
`timescale 1ns / 1ps
// result checker for the servo drive regulator: predicts each result beat and compares it
module servo_drive_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  mscld_pkg::t_in_beat  i_in_beat,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  mscld_pkg::t_out_beat i_out_beat,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [11:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    import mscld_pkg::*;

    localparam int unsigned N_SERVO    = NUM_SERVOS_DEF;
    localparam int unsigned DIV        = SPEED_DIV_DEF;
    localparam int unsigned LEVEL_STEP = 4;
    localparam int unsigned ANGLE_DEN  = 100;

    logic [11:0] floor_q;
    logic [15:0] level_q     [N_SERVO];
    logic [7:0]  tgt_angle_q [N_SERVO];
    logic [7:0]  limit_q     [N_SERVO];
    logic [7:0]  speed_q     [N_SERVO];
    t_mode       mode_q      [N_SERVO];
    logic        was_zero_q  [N_SERVO];
    t_mode       latch_q;

    t_out_beat expected_q [$];
    int fails = 0;
    int checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    task automatic clear_state();
        floor_q = RST_PWM_FLOOR;
        for (int i = 0; i < N_SERVO; i++) begin
            level_q[i]     = 16'(RST_PWM_FLOOR * DIV);
            tgt_angle_q[i] = '0;
            limit_q[i]     = DEFAULT_CURRENT_DEF;
            speed_q[i]     = 8'd1;
            mode_q[i]      = MODE_FOLLOW;
            was_zero_q[i]  = 1'b1;
        end
        latch_q = MODE_FOLLOW;
    endtask

    function automatic int unsigned angle_to_level(input int unsigned deg);
        return (int'(floor_q) + ((deg * DEG_SCALE) / ANGLE_GAIN) * LEVEL_STEP) * DIV;
    endfunction

    function automatic int unsigned level_to_angle(input int unsigned lvl);
        int unsigned c;
        int unsigned a;
        c = lvl / DIV;
        if (c < floor_q) return 0;
        a = ((c - floor_q) * ANGLE_GAIN) / ANGLE_DEN;
        return (a > ANGLE_SAT) ? ANGLE_SAT : a;
    endfunction

    function automatic t_out_beat drive_regulate(input t_in_beat b);
        t_out_beat r;
        int        lvl;
        int        tgt;
        int        minl;
        int        cmp;
        int        a;
        int        s;
        logic      ok;
        logic      over;
        ok = b.servo_index < N_SERVO;
        s  = b.servo_index;
        if (b.opcode == OP_SET_MODE) begin
            if (b.set_value <= MODE_VALUE_MAX) begin
                if (latch_q != MODE_FOLLOW) begin
                    for (int i = 0; i < N_SERVO; i++) mode_q[i] = t_mode'(b.set_value[1:0]);
                end
                latch_q = t_mode'(b.set_value[1:0]);
            end
        end else if (ok && b.opcode == OP_SET_ANGLE) begin
            a = b.set_value;
            if (a < ANGLE_MIN) a = ANGLE_MIN;
            if (a > ANGLE_MAX) a = ANGLE_MAX;
            tgt_angle_q[s] = a[7:0];
            mode_q[s] = latch_q;
        end else if (ok && b.opcode == OP_SET_LIMIT) begin
            limit_q[s] = b.set_value;
            mode_q[s] = latch_q;
        end else if (ok && b.opcode == OP_SET_SPEED) begin
            speed_q[s] = b.set_value;
            mode_q[s] = latch_q;
        end

        r = '0;
        r.servo_echo = b.servo_index;
        if (!ok) return r;

        if (b.opcode == OP_TICK) begin
            lvl  = level_q[s];
            tgt  = angle_to_level(tgt_angle_q[s]);
            minl = int'(floor_q) * DIV;
            over = b.measured_current >= limit_q[s];
            case (mode_q[s])
                MODE_ANGLE: begin
                    if (over) begin
                        lvl = 0;
                    end else if (lvl < tgt) begin
                        lvl = lvl + speed_q[s];
                        if (lvl > tgt) lvl = tgt;
                    end else if (lvl > tgt) begin
                        lvl = lvl - speed_q[s];
                        if (lvl < tgt) lvl = tgt;
                    end
                end
                MODE_HOLD: begin
                    if (!over) begin
                        lvl = lvl + 1;
                        if (lvl > tgt) lvl = tgt;
                    end else begin
                        lvl = lvl - HOLD_BACKOFF;
                        if (lvl < minl) lvl = minl;
                    end
                end
                default: begin
                    if (was_zero_q[s] && b.measured_current < CUR_FOLLOW_MAX)
                        lvl = angle_to_level(b.measured_angle);
                    else
                        lvl = 0;
                end
            endcase
            was_zero_q[s] = (lvl == 0);
            if (lvl >= minl) level_q[s] = lvl[15:0];
            cmp = lvl / DIV;
        end else begin
            cmp = level_q[s] / DIV;
        end

        r.drive_compare  = (cmp > CMP_MAX) ? CMP_MAX : cmp[12:0];
        r.reported_angle = 8'(level_to_angle(level_q[s]));
        r.reported_speed = (b.measured_current > CUR_SPEED_MIN
                            && b.measured_current < limit_q[s]) ? speed_q[s] : '0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            clear_state();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) floor_q = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result beat for servo %0d with no expectation waiting",
                           i_out_beat.servo_echo);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("servo_echo", want.servo_echo, i_out_beat.servo_echo);
                    check_field("drive_compare", want.drive_compare, i_out_beat.drive_compare);
                    check_field("reported_angle", want.reported_angle,
                                i_out_beat.reported_angle);
                    check_field("reported_speed", want.reported_speed,
                                i_out_beat.reported_speed);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(drive_regulate(i_in_beat));
        end
        o_pending <= expected_q.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// top of the servo drive regulator testbench: clock, reset, stimulus and verdict
module tb;
    import mscld_pkg::*;

    localparam int unsigned LATENCY         = 7;
    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned N_PHASES        = 5;
    localparam int unsigned ITEMS_PER_PHASE = 80;
    localparam int unsigned CHUNK           = 20;
    localparam logic [2:0]  OP_UNUSED_LO    = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI    = 3'd7;
    localparam logic [2:0]  IDX_MAX         = 3'd7;
    localparam logic [11:0] FLOOR_MAX       = 12'hFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_beat;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_beat;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned n_items = 0;
    int unsigned n_settings = 1;
    int unsigned stall_left = 0;
    int unsigned stuck = 0;
    bit          idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multi_servo_current_limited_drive DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    servo_drive_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_beat   (o_out_beat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    initial begin
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_item(input logic [2:0] op, input logic [2:0] idx,
                             input logic [7:0] val, input logic [7:0] ang,
                             input logic [7:0] cur);
        t_in_beat b;
        b.opcode           = op;
        b.servo_index      = idx;
        b.set_value        = val;
        b.measured_angle   = ang;
        b.measured_current = cur;
        send_beat(b);
    endtask

    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned r;
        b.servo_index    = 3'($urandom_range(0, NUM_SERVOS_DEF - 1));
        b.set_value      = 8'($urandom);
        b.measured_angle = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30)      b.measured_current = 8'($urandom_range(0, CUR_FOLLOW_MAX - 1));
        else if (r < 60) b.measured_current = 8'($urandom_range(CUR_SPEED_MIN + 1, 60));
        else if (r < 80) b.measured_current = 8'($urandom_range(150, 255));
        else             b.measured_current = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            b.opcode = OP_TICK;
        end else if (r < 63) begin
            b.opcode    = OP_SET_MODE;
            b.set_value = 8'($urandom_range(0, MODE_VALUE_MAX));
        end else if (r < 73) begin
            b.opcode = OP_SET_ANGLE;
        end else if (r < 80) begin
            b.opcode = OP_SET_LIMIT;
        end else if (r < 88) begin
            b.opcode = OP_SET_SPEED;
            if ($urandom_range(0, 1) != 0) b.set_value = 8'($urandom_range(0, 16));
        end else if (r < 93) begin
            b.opcode      = 3'($urandom_range(0, OP_UNUSED_HI));
            b.servo_index = 3'($urandom_range(NUM_SERVOS_DEF, IDX_MAX));
        end else if (r < 96) begin
            b.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            b.opcode    = OP_SET_MODE;
            b.set_value = 8'($urandom_range(MODE_VALUE_MAX + 1, 255));
        end
        return b;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [11:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_beat   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // follow mode: copy, zero, copy again after a zero drive, then zero at current five
        send_item(OP_TICK, 0, 8'd90, 8'd90, 8'd0);
        send_item(OP_TICK, 0, 8'd0, 8'd255, 8'd4);
        send_item(OP_TICK, 0, 8'd0, 8'd255, 8'd4);
        send_item(OP_TICK, 0, 8'd255, 8'd0, 8'd5);
        // latched mode still follow, so only the latch moves
        send_item(OP_SET_MODE, 0, 8'(MODE_ANGLE), 8'd0, 8'd0);
        send_item(OP_SET_ANGLE, 1, 8'd0, 8'd0, 8'd0);
        send_item(OP_SET_ANGLE, 1, 8'd255, 8'd0, 8'd0);
        send_item(OP_SET_SPEED, 1, 8'd255, 8'd0, 8'd11);
        send_item(OP_TICK, 1, 8'd0, 8'd0, 8'd0);
        send_item(OP_TICK, 1, 8'd0, 8'd0, 8'd199);
        send_item(OP_TICK, 1, 8'd0, 8'd0, 8'd200);
        send_item(OP_SET_ANGLE, 2, 8'd1, 8'd0, 8'd10);
        send_item(OP_TICK, 2, 8'd0, 8'd0, 8'd0);
        // index out of range still sets every servo mode
        send_item(OP_SET_MODE, IDX_MAX, 8'(MODE_HOLD), 8'd0, 8'd0);
        send_item(OP_TICK, 1, 8'd0, 8'd0, 8'd0);
        send_item(OP_SET_LIMIT, 3, 8'd0, 8'd0, 8'd0);
        send_item(OP_TICK, 3, 8'd0, 8'd0, 8'd0);
        send_item(OP_SET_MODE, 0, MODE_VALUE_MAX + 8'd1, 8'd0, 8'd0);
        send_item(OP_SET_MODE, 0, 8'd255, 8'd0, 8'd0);
        send_item(OP_TICK, 3'(NUM_SERVOS_DEF), 8'd0, 8'd255, 8'd255);
        send_item(OP_SET_SPEED, IDX_MAX, 8'd255, 8'd255, 8'd20);
        send_item(OP_UNUSED_HI, 4, 8'd255, 8'd255, 8'd20);
        send_item(OP_UNUSED_LO, 2, 8'd0, 8'd0, 8'd0);
        send_item(OP_SET_MODE, 4, 8'(MODE_FOLLOW), 8'd0, 8'd0);
        send_item(OP_TICK, 4, 8'd0, 8'd128, 8'd255);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: ;
                1: write_floor('0);
                2: write_floor(FLOOR_MAX);
                default: write_floor(12'($urandom_range(0, FLOOR_MAX)));
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % CHUNK == 0) idle_on = ($urandom_range(0, 3) != 0);
                send_beat(random_beat());
            end
        end
        wait_drained();

        $display("covered %0d input beats over %0d pwm floor settings, floor 0 and %0d included",
                 n_items, n_settings, FLOOR_MAX);
        $display("%0d result beats compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
